>>> hw/rtl/cfd_pkg.sv
package cfd_pkg;

   localparam int OPCODE_W  = 2;
   localparam int CHANNEL_W = 9;
   localparam int FRAME_W   = 32;
   localparam int LEVEL_W   = 8;
   localparam int LENGTH_W  = 16;
   localparam int SLOPE_W   = 9;
   localparam int TOL_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_PRIME  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

   // Register index, taken from paddr bit 2 (registers are 4 bytes apart).
   localparam logic REG_SLOPE_TOLERANCE = 1'b0;
   localparam logic REG_MIN_FADE_FRAMES = 1'b1;

   localparam logic [TOL_W-1:0]    SLOPE_TOLERANCE_RESET = 8'd1;
   localparam logic [LENGTH_W-1:0] MIN_FADE_FRAMES_RESET = 16'd2;

   typedef struct packed {
      logic [TOL_W-1:0]    slope_tolerance;
      logic [LENGTH_W-1:0] min_fade_frames;
   } cfd_cfg_type;

   // One channel's record as stored in the channel memory.
   typedef struct packed {
      logic [LEVEL_W-1:0]        previous_level;
      logic [FRAME_W-1:0]        run_start_frame;
      logic [LEVEL_W-1:0]        run_first_level;
      logic [LEVEL_W-1:0]        run_last_level;
      logic [LENGTH_W-1:0]       run_frames;
      logic signed [SLOPE_W-1:0] run_slope;
   } cfd_entry_type;

endpackage

>>> hw/rtl/cfd_req_if.sv
interface cfd_req_if;
   import cfd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [CHANNEL_W-1:0] channel;
   logic [FRAME_W-1:0]   frame_number;
   logic [LEVEL_W-1:0]   level;

   modport source (output valid, output opcode, output channel, output frame_number,
                   output level, input ready);
   modport sink   (input valid, input opcode, input channel, input frame_number,
                   input level, output ready);
endinterface

interface cfd_rsp_if;
   import cfd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] fade_channel;
   logic [LEVEL_W-1:0]   from_level;
   logic [LEVEL_W-1:0]   to_level;
   logic [FRAME_W-1:0]   fade_start;
   logic [LENGTH_W-1:0]  fade_length;

   modport source (output valid, output fade_channel, output from_level, output to_level,
                   output fade_start, output fade_length, input ready);
   modport sink   (input valid, input fade_channel, input from_level, input to_level,
                   input fade_start, input fade_length, output ready);
endinterface

>>> hw/rtl/cfd_ram.sv
module cfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/cfd_csr.sv
module cfd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfd_pkg::cfd_cfg_type           cfg
);
   import cfd_pkg::*;

   cfd_cfg_type cfg_ff;
   cfd_cfg_type cfg_in;
   logic        wr_strobe;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (csr_paddr[2])
            REG_SLOPE_TOLERANCE: cfg_in.slope_tolerance = csr_pwdata[TOL_W-1:0];
            REG_MIN_FADE_FRAMES: cfg_in.min_fade_frames = csr_pwdata[LENGTH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SLOPE_TOLERANCE: csr_prdata = CSR_DATA_W'(cfg_ff.slope_tolerance);
         REG_MIN_FADE_FRAMES: csr_prdata = CSR_DATA_W'(cfg_ff.min_fade_frames);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slope_tolerance <= SLOPE_TOLERANCE_RESET;
         cfg_ff.min_fade_frames <= MIN_FADE_FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> hw/rtl/channel_fade_detector_unit.sv
// Per-channel fade detector. Every channel keeps one record (previous level and the
// open run) in a memory of CHANNELS words with one read port and one write port. A
// request word reads its channel's record at the edge where it is accepted and enters
// the update stage; the record is updated and written back, and any fade record loaded
// into the output register, at the edge where that stage advances. A word for the same
// channel right behind is served from a forwarding register. The block takes one request
// word per cycle unless clearing or held. While a fade word waits in the output register
// and the receiver does not take it, the update stage holds, with req.ready low once it
// holds a word. After reset the memory is swept clear with req.ready low; configuration
// writes are taken during the sweep.
module channel_fade_detector_unit #(
   parameter int CHANNELS = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   cfd_req_if.sink                        req,
   cfd_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cfd_pkg::*;

   localparam int ADDR_W  = $clog2(CHANNELS > 1 ? CHANNELS : 2);
   localparam int ENTRY_W = $bits(cfd_entry_type);

   cfd_cfg_type cfg;

   cfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Clearing sweep after reset.
   logic              clearing_ff, clearing_in;
   logic [ADDR_W:0]   clr_cnt_ff, clr_cnt_in;

   // Update stage.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_in_range_ff;
   logic [OPCODE_W-1:0]  s1_opcode_ff;
   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [FRAME_W-1:0]   s1_frame_ff;
   logic [LEVEL_W-1:0]   s1_level_ff;

   // Last word written back, for a request read in the same cycle.
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   cfd_entry_type        fwd_data_ff;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0] rsp_channel_ff;
   logic [LEVEL_W-1:0]   rsp_from_ff;
   logic [LEVEL_W-1:0]   rsp_to_ff;
   logic [FRAME_W-1:0]   rsp_start_ff;
   logic [LENGTH_W-1:0]  rsp_length_ff;

   logic                 req_accept;
   logic                 s1_advance;
   logic [ADDR_W-1:0]    req_addr;
   logic                 req_in_range;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;

   cfd_entry_type           cur;
   cfd_entry_type           nxt;
   logic                    do_write;
   logic                    emit;
   logic signed [SLOPE_W:0] delta;
   logic signed [SLOPE_W+1:0] delta_x, lo_bound, hi_bound;
   logic                    out_of_slope;
   logic [LENGTH_W-1:0]     base_frames;

   assign req_addr     = ADDR_W'({{ADDR_W{1'b0}}, req.channel});
   assign req_in_range = 32'(req.channel) < 32'(CHANNELS);

   assign s1_advance = !rsp_valid_ff || rsp.ready;
   assign req.ready  = !clearing_ff && (!s1_valid_ff || s1_advance);
   assign req_accept = req.valid && req.ready;

   cfd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Read-modify-write of one channel record.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur = fwd_data_ff;
      end else begin
         cur = cfd_entry_type'(ram_rd_data);
      end

      delta    = $signed({2'b00, s1_level_ff}) - $signed({2'b00, cur.previous_level});
      delta_x  = (SLOPE_W+2)'(delta);
      lo_bound = (SLOPE_W+2)'(cur.run_slope) - $signed({3'b000, cfg.slope_tolerance});
      hi_bound = (SLOPE_W+2)'(cur.run_slope) + $signed({3'b000, cfg.slope_tolerance});
      out_of_slope = (delta_x < lo_bound) || (delta_x > hi_bound);

      nxt         = cur;
      do_write    = 1'b0;
      emit        = 1'b0;
      base_frames = cur.run_frames;

      if (s1_in_range_ff) begin
         unique case (s1_opcode_ff)
            OP_PRIME: begin
               do_write           = 1'b1;
               nxt.previous_level = s1_level_ff;
            end
            OP_SAMPLE: begin
               do_write           = 1'b1;
               nxt.previous_level = s1_level_ff;
               if (delta == '0) begin
                  emit                = 1'b1;
                  nxt.run_start_frame = '0;
                  nxt.run_first_level = '0;
                  nxt.run_last_level  = '0;
                  nxt.run_frames      = '0;
                  nxt.run_slope       = '0;
               end else begin
                  if ((cur.run_frames != '0) && out_of_slope) begin
                     emit        = 1'b1;
                     base_frames = '0;
                  end
                  nxt.run_slope      = delta[SLOPE_W-1:0];
                  nxt.run_last_level = s1_level_ff;
                  if (base_frames == '0) begin
                     nxt.run_start_frame = s1_frame_ff;
                     nxt.run_first_level = cur.previous_level;
                  end else begin
                     nxt.run_start_frame = cur.run_start_frame;
                     nxt.run_first_level = cur.run_first_level;
                  end
                  if (&base_frames) begin
                     nxt.run_frames = base_frames;
                  end else begin
                     nxt.run_frames = base_frames + LENGTH_W'(1);
                  end
               end
            end
            OP_FLUSH: begin
               do_write            = 1'b1;
               emit                = 1'b1;
               nxt.run_start_frame = '0;
               nxt.run_first_level = '0;
               nxt.run_last_level  = '0;
               nxt.run_frames      = '0;
               nxt.run_slope       = '0;
            end
            default: begin
               do_write = 1'b0;
            end
         endcase
      end

      // A run is reported only if it is not empty and long enough.
      emit = emit && (cur.run_frames != '0) && (cur.run_frames >= cfg.min_fade_frames);
   end

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff[ADDR_W-1:0];
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_valid_ff && s1_advance && do_write;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = ENTRY_W'(nxt);
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + (ADDR_W+1)'(1);
         if (clr_cnt_ff == (ADDR_W+1)'(CHANNELS - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      fwd_valid_in = fwd_valid_ff || (!clearing_ff && ram_wr_en);

      if (s1_valid_ff && s1_advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_in_range_ff <= req_in_range;
         s1_opcode_ff   <= req.opcode;
         s1_channel_ff  <= req.channel;
         s1_addr_ff     <= req_addr;
         s1_frame_ff    <= req.frame_number;
         s1_level_ff    <= req.level;
      end
      if (!clearing_ff && ram_wr_en) begin
         fwd_addr_ff <= ram_wr_addr;
         fwd_data_ff <= nxt;
      end
      if (s1_valid_ff && s1_advance && emit) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_from_ff    <= cur.run_first_level;
         rsp_to_ff      <= cur.run_last_level;
         rsp_start_ff   <= cur.run_start_frame;
         rsp_length_ff  <= cur.run_frames;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.fade_channel = rsp_channel_ff;
   assign rsp.from_level   = rsp_from_ff;
   assign rsp.to_level     = rsp_to_ff;
   assign rsp.fade_start   = rsp_start_ff;
   assign rsp.fade_length  = rsp_length_ff;
endmodule
